/* src/lphs_pkg.sv */
// ----------------------------------------------------------------------------
// Linear probe hash set package
// Table geometry, field widths, codes and the control/status structures
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int TABLE_SIZE   = 4096;
  localparam int HASH_MODULUS = 4095;

  localparam int MODE_W       = 2;
  localparam int KEY_W        = 31;
  localparam int STATUS_W     = 3;
  localparam int SLOT_W       = 12;
  localparam int SLOT_STATE_W = 2;

  localparam int IDX_W     = $clog2(TABLE_SIZE);
  localparam bit NEED_FOLD = (HASH_MODULUS > TABLE_SIZE);

  localparam int RECIP_W  = KEY_W + 2;
  localparam int PROD_W   = KEY_W + RECIP_W;
  localparam int HM_SHIFT = KEY_W + $clog2(HASH_MODULUS);
  localparam int TS_SHIFT = KEY_W + $clog2(TABLE_SIZE);
  localparam logic [RECIP_W-1:0] HM_RECIP =
    RECIP_W'((64'd1 << HM_SHIFT) / 64'(HASH_MODULUS) + 64'd1);
  localparam logic [RECIP_W-1:0] TS_RECIP =
    RECIP_W'((64'd1 << TS_SHIFT) / 64'(TABLE_SIZE) + 64'd1);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_ADDED   = 3'd0,
    RES_PRESENT = 3'd1,
    RES_FULL    = 3'd2,
    RES_FOUND   = 3'd3,
    RES_MISSING = 3'd4,
    RES_DELETED = 3'd5
  } status_e;

  typedef enum logic [SLOT_STATE_W-1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_CHK,
    S_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic req_ready;
    logic req_load;
    logic mod_start;
    logic idx_home;
    logic idx_step;
    logic note;
    logic commit;
    logic clr_step;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic op_valid;
    logic mod_done;
    logic probe_stop;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

/* src/lphs_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request item: operation mode and key.
// ----------------------------------------------------------------------------
interface lphs_req_if import lphs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

/* src/lphs_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item: status code and slot index.
// ----------------------------------------------------------------------------
interface lphs_rsp_if import lphs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

/* src/lphs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lphs_mod_unit.sv */
// ----------------------------------------------------------------------------
// Home slot unit
// Remainder of the key by the hash modulus through a product with a scaled
// reciprocal, each pass forming the product and then the remainder, with an
// optional second pass by the table size.
// ----------------------------------------------------------------------------
module lphs_mod_unit import lphs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] dividend_i,
  output logic             done_o,
  output logic [IDX_W-1:0] home_o
);

  logic              busy_q, busy_d;
  logic              sub_q, sub_d;
  logic              fold_q, fold_d;
  logic              done_q, done_d;
  logic [KEY_W-1:0]  num_q, num_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  rem;

  assign quot = fold_q ? KEY_W'(prod_q >> TS_SHIFT) : KEY_W'(prod_q >> HM_SHIFT);
  assign rem  = fold_q ? num_q - quot * KEY_W'(TABLE_SIZE)
                       : num_q - quot * KEY_W'(HASH_MODULUS);

  always_comb begin
    busy_d = busy_q;
    sub_d  = sub_q;
    fold_d = fold_q;
    done_d = 1'b0;
    num_d  = num_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      sub_d  = 1'b0;
      fold_d = 1'b0;
      num_d  = dividend_i;
    end else if (busy_q) begin
      if (!sub_q) begin
        prod_d = fold_q ? PROD_W'(num_q) * PROD_W'(TS_RECIP)
                        : PROD_W'(num_q) * PROD_W'(HM_RECIP);
        sub_d  = 1'b1;
      end else begin
        num_d = rem;
        sub_d = 1'b0;
        if (NEED_FOLD && !fold_q) begin
          fold_d = 1'b1;
        end else begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sub_q  <= 1'b0;
      fold_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      sub_q  <= sub_d;
      fold_q <= fold_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign home_o = num_q[IDX_W-1:0];

endmodule

/* src/lphs_ctrl.sv */
// ----------------------------------------------------------------------------
// Hash set controller
// Sequences the clearing pass, home slot computation, probe loop, table
// update and result hand-off.
// ----------------------------------------------------------------------------
module lphs_ctrl import lphs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (sts_i.req_valid) begin
          state_d = sts_i.op_valid ? S_MOD : S_DONE;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = sts_i.probe_stop ? S_WR : S_RD;
      end
      S_WR: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        cmd_o.req_ready = 1'b1;
        cmd_o.req_load  = sts_i.req_valid;
        cmd_o.mod_start = sts_i.req_valid && sts_i.op_valid;
      end
      S_MOD: begin
        cmd_o.idx_home = sts_i.mod_done;
      end
      S_RD: begin
      end
      S_CHK: begin
        cmd_o.note     = 1'b1;
        cmd_o.idx_step = !sts_i.probe_stop;
      end
      S_WR: begin
        cmd_o.commit = 1'b1;
      end
      S_DONE: begin
        cmd_o.res_load = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/lphs_datapath.sv */
// ----------------------------------------------------------------------------
// Hash set datapath
// Request registers, slot key and slot state memories, probe index and
// counter, hit and free slot tracking, and the result output register.
// ----------------------------------------------------------------------------
module lphs_datapath import lphs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lphs_req_if.sink          req_i,
  lphs_rsp_if.source        rsp_o,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        sts_o
);

  logic [MODE_W-1:0]       mode_q;
  logic [KEY_W-1:0]        key_q;
  logic [IDX_W-1:0]        idx_q;
  logic [IDX_W-1:0]        cnt_q;
  logic                    found_q;
  logic [IDX_W-1:0]        hit_idx_q;
  logic                    free_valid_q;
  logic [IDX_W-1:0]        free_idx_q;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [IDX_W-1:0]        out_slot_q;

  logic [KEY_W-1:0]        key_rdata;
  logic [SLOT_STATE_W-1:0] state_rdata;
  logic                    st_we;
  logic [IDX_W-1:0]        st_waddr;
  logic [SLOT_STATE_W-1:0] st_wdata;
  logic                    key_we;
  logic                    hit;
  logic                    empty;
  logic                    last;
  logic [IDX_W-1:0]        idx_next;
  logic                    mod_done;
  logic [IDX_W-1:0]        home;
  status_e                 res_status;
  logic [IDX_W-1:0]        res_slot;

  lphs_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (req_i.key),
    .done_o     (mod_done),
    .home_o     (home)
  );

  lphs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SIZE)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (key_rdata)
  );

  lphs_ram #(
    .WIDTH (SLOT_STATE_W),
    .DEPTH (TABLE_SIZE)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (idx_q),
    .rdata_o (state_rdata)
  );

  assign hit      = (state_rdata == SLOT_USED) && (key_rdata == key_q);
  assign empty    = (state_rdata == SLOT_EMPTY);
  assign last     = (cnt_q == IDX_W'(TABLE_SIZE-1));
  assign idx_next = (idx_q == IDX_W'(TABLE_SIZE-1)) ? '0 : idx_q + 1'b1;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx_q;
    st_wdata = SLOT_EMPTY;
    key_we   = 1'b0;
    if (cmd_i.clr_step) begin
      st_we = 1'b1;
    end else if (cmd_i.commit) begin
      if ((mode_q == MODE_INSERT) && !found_q && free_valid_q) begin
        st_we    = 1'b1;
        st_waddr = free_idx_q;
        st_wdata = SLOT_USED;
        key_we   = 1'b1;
      end else if ((mode_q == MODE_DELETE) && found_q) begin
        st_we    = 1'b1;
        st_waddr = hit_idx_q;
        st_wdata = SLOT_TOMB;
      end
    end
  end

  always_comb begin
    res_status = RES_MISSING;
    res_slot   = '0;
    unique case (mode_q)
      MODE_INSERT: begin
        if (found_q) begin
          res_status = RES_PRESENT;
        end else if (free_valid_q) begin
          res_status = RES_ADDED;
          res_slot   = free_idx_q;
        end else begin
          res_status = RES_FULL;
        end
      end
      MODE_SEARCH: begin
        if (found_q) begin
          res_status = RES_FOUND;
          res_slot   = hit_idx_q;
        end
      end
      MODE_DELETE: begin
        if (found_q) begin
          res_status = RES_DELETED;
          res_slot   = hit_idx_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      free_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_step || cmd_i.idx_step) begin
        idx_q <= idx_next;
      end else if (cmd_i.idx_home) begin
        idx_q <= home;
      end
      if (cmd_i.idx_home) begin
        cnt_q <= '0;
      end else if (cmd_i.idx_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.req_load) begin
        found_q      <= 1'b0;
        free_valid_q <= 1'b0;
      end else if (cmd_i.note) begin
        if (hit) begin
          found_q <= 1'b1;
        end
        if (state_rdata != SLOT_USED) begin
          free_valid_q <= 1'b1;
        end
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.key;
    end
    if (cmd_i.note && hit) begin
      hit_idx_q <= idx_q;
    end
    if (cmd_i.note && !free_valid_q && (state_rdata != SLOT_USED)) begin
      free_idx_q <= idx_q;
    end
    if (cmd_i.res_load) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
    end
  end

  assign req_i.ready  = cmd_i.req_ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.slot   = SLOT_W'(out_slot_q);

  assign sts_o.req_valid  = req_i.valid;
  assign sts_o.op_valid   = (req_i.mode == MODE_INSERT) || (req_i.mode == MODE_SEARCH) ||
                            (req_i.mode == MODE_DELETE);
  assign sts_o.mod_done   = mod_done;
  assign sts_o.probe_stop = hit || empty || last;
  assign sts_o.clr_last   = (idx_q == IDX_W'(TABLE_SIZE-1));
  assign sts_o.out_free   = !out_valid_q || rsp_o.ready;

endmodule

/* src/linear_probe_hash_set_core.sv */
// ----------------------------------------------------------------------------
// Linear probe hash set core
// Open addressing hash set of 31-bit keys with insert, search and delete.
// ----------------------------------------------------------------------------
// Requests arrive as items on req_i (mode, key) and each one yields exactly
// one result item on rsp_o (status, slot), in request order.
// The home slot is found through a product with a scaled reciprocal of the
// hash modulus, the remainder, and the hand-over to the probe loop; a second
// product and remainder by the table size are added when the hash modulus
// exceeds the table size. Each probe is a registered memory read followed by
// a step that examines it. A request with an unused mode is not probed and
// goes straight to the result hand-off.
// One request is worked on at a time; the next is accepted once the result
// of the previous one sits in the output register, even while the receiver
// stalls. A further result waits in the controller until that register is
// taken, and no new request is accepted meanwhile.
// After reset the slot state memory is swept to empty, one slot per cycle,
// over all TABLE_SIZE (4096) slots; req_i.ready stays low throughout.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core import lphs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lphs_req_if.sink   req_i,
  lphs_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  lphs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lphs_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> sts.out_free)
    else $error("Result loaded while the output register was still occupied.");

  a_load_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |=> rsp_o.valid)
    else $error("Loaded result did not appear on the response channel.");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !(req_i.valid && req_i.ready))
    else $error("Request item accepted during the clearing pass.");

  a_mod_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.mod_done |-> !cmd.req_ready)
    else $error("Home slot finished while the controller was idle.");

endmodule
